[rtl/serial_packet_deframer_xor_check_unit_defines.svh]
// Assertion macros shared by the deframer modules.
`ifndef SERIAL_PACKET_DEFRAMER_XOR_CHECK_UNIT_DEFINES_SVH
`define SERIAL_PACKET_DEFRAMER_XOR_CHECK_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is asserted.
`define SPDX_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define SPDX_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define SPDX_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define SPDX_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

[rtl/spdx_pkg.sv]
// Types and constants shared by the serial packet deframer.
`default_nettype none
package spdx_pkg;

    localparam int PAY_INDEX_W = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] START_CMD  = 8'hFF;
    localparam logic [7:0] START_DATA = 8'hFE;
    localparam logic [7:0] START_ACK  = 8'hFD;

    localparam logic [1:0] EV_PAYLOAD = 2'd0;
    localparam logic [1:0] EV_CMD     = 2'd1;
    localparam logic [1:0] EV_DATA    = 2'd2;
    localparam logic [1:0] EV_ACK     = 2'd3;

    typedef enum logic [1:0] {
        MODE_HUNT,
        MODE_CMD,
        MODE_DATA,
        MODE_ACK
    } mode_t;

    typedef enum logic [2:0] {
        TOK_CMD_HDR,
        TOK_DATA_HDR,
        TOK_PAY,
        TOK_CMD_SUM,
        TOK_DATA_SUM,
        TOK_ACK
    } tok_kind_t;

    // One classified byte passed from front to back.
    typedef struct packed {
        tok_kind_t              kind;
        logic                   first;
        logic [7:0]             data;
        logic [PAY_INDEX_W-1:0] index;
    } tok_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       overrun;
    } in_t;

    typedef struct packed {
        logic [1:0]             event_res;
        logic [7:0]             payload_byte;
        logic [PAY_INDEX_W-1:0] payload_index;
        logic [7:0]             field_a;
        logic [7:0]             field_b;
        logic [7:0]             field_c;
        logic [7:0]             field_d;
        logic                   check_ok;
    } out_t;

endpackage
`default_nettype wire

[rtl/spdx_front.sv]
// Front end: hunts for start bytes, tracks packet position, classifies words.
`default_nettype none
module spdx_front #(
    parameter int PAYLOAD_BYTES = 512
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    input  wire logic          item_stall,
    input  wire spdx_pkg::in_t item,
    output logic               push,
    output spdx_pkg::tok_t     push_tok
);
    import spdx_pkg::*;

    localparam int CNT_W = $clog2(PAYLOAD_BYTES + 5);
    localparam int IDX_W = (CNT_W > PAY_INDEX_W) ? CNT_W : PAY_INDEX_W;
    localparam logic [CNT_W-1:0] CNT_ONE      = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_CMD_LAST = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_DAT_LAST = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_PAY_FST  = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_PAY_END  = CNT_W'(4 + PAYLOAD_BYTES);

    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             take;
    logic [CNT_W-1:0] slot_full;
    logic [IDX_W-1:0] pay_full;
    logic [PAY_INDEX_W-1:0] slot_index;

    assign take       = item_valid && !item_stall && !item.overrun;
    assign slot_full  = count_reg - CNT_ONE;
    assign slot_index = {{(PAY_INDEX_W-2){1'b0}}, slot_full[1:0]};
    assign pay_full   = IDX_W'(count_reg) - IDX_W'(4);

    // Hold mode and position in packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_HUNT;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    // Classify the word and advance the packet position
    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        push           = 1'b0;
        push_tok.kind  = TOK_ACK;
        push_tok.first = 1'b0;
        push_tok.data  = item.rx_byte;
        push_tok.index = '0;
        if (take)
        begin
            unique case (mode_reg)
                MODE_HUNT:
                begin
                    priority if (item.rx_byte == START_CMD)
                    begin
                        mode_next  = MODE_CMD;
                        count_next = CNT_ONE;
                    end
                    else if (item.rx_byte == START_DATA)
                    begin
                        mode_next  = MODE_DATA;
                        count_next = CNT_ONE;
                    end
                    else if (item.rx_byte == START_ACK)
                    begin
                        mode_next  = MODE_ACK;
                        count_next = CNT_ONE;
                    end
                    else
                    begin
                        mode_next = MODE_HUNT;
                    end
                end
                MODE_CMD:
                begin
                    push = 1'b1;
                    if (count_reg >= CNT_ONE && count_reg <= CNT_CMD_LAST)
                    begin
                        push_tok.kind  = TOK_CMD_HDR;
                        push_tok.first = (count_reg == CNT_ONE);
                        push_tok.index = slot_index;
                        count_next     = count_reg + CNT_ONE;
                    end
                    else
                    begin
                        push_tok.kind = TOK_CMD_SUM;
                        mode_next     = MODE_HUNT;
                        count_next    = '0;
                    end
                end
                MODE_DATA:
                begin
                    push = 1'b1;
                    priority if (count_reg >= CNT_ONE && count_reg <= CNT_DAT_LAST)
                    begin
                        push_tok.kind  = TOK_DATA_HDR;
                        push_tok.index = slot_index;
                        count_next     = count_reg + CNT_ONE;
                    end
                    else if (count_reg >= CNT_PAY_FST && count_reg < CNT_PAY_END)
                    begin
                        push_tok.kind  = TOK_PAY;
                        push_tok.first = (count_reg == CNT_PAY_FST);
                        push_tok.index = pay_full[PAY_INDEX_W-1:0];
                        count_next     = count_reg + CNT_ONE;
                    end
                    else
                    begin
                        push_tok.kind = TOK_DATA_SUM;
                        mode_next     = MODE_HUNT;
                        count_next    = '0;
                    end
                end
                MODE_ACK:
                begin
                    push          = 1'b1;
                    push_tok.kind = TOK_ACK;
                    mode_next     = MODE_HUNT;
                    count_next    = '0;
                end
                default:
                begin
                    mode_next  = MODE_HUNT;
                    count_next = '0;
                end
            endcase
        end
    end

    `include "serial_packet_deframer_xor_check_unit_defines.svh"

    `SPDX_ASSERT_IMPL(a_hunt_count, clk, rst_n, mode_reg == MODE_HUNT, count_reg == '0)
    `SPDX_ASSERT_IMPL(a_pkt_count, clk, rst_n, mode_reg != MODE_HUNT, count_reg != '0)

endmodule
`default_nettype wire

[rtl/spdx_fifo.sv]
// Short queue of classified words between front and back.
`default_nettype none
module spdx_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire spdx_pkg::tok_t  push_tok,
    input  wire logic            pop,
    output logic                 full,
    output logic                 not_empty,
    output spdx_pkg::tok_t       head
);
    import spdx_pkg::*;

    tok_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_tok;
        end
    end

    // Track fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    `include "serial_packet_deframer_xor_check_unit_defines.svh"

    `SPDX_ASSERT_IMPL(a_no_overfill, clk, rst_n, push, !full || pop)
    `SPDX_ASSERT_IMPL(a_no_underrun, clk, rst_n, pop, not_empty)

endmodule
`default_nettype wire

[rtl/spdx_back.sv]
// Back end: keeps header bytes and running XOR, builds result words.
`default_nettype none
module spdx_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            not_empty,
    input  wire spdx_pkg::tok_t  head,
    output logic                 pop,
    output logic                 res_valid,
    input  wire logic            res_stall,
    output spdx_pkg::out_t       res
);
    import spdx_pkg::*;

    logic [7:0] hdr_reg [4];
    logic [7:0] xor_reg, xor_next;
    logic       valid_reg, valid_next;
    out_t       res_reg, res_next;
    logic       emits;
    logic [1:0] slot;

    assign emits     = (head.kind != TOK_CMD_HDR) && (head.kind != TOK_DATA_HDR);
    assign pop       = not_empty && (!emits || !valid_reg || !res_stall);
    assign slot      = head.index[1:0];
    assign res_valid = valid_reg;
    assign res       = res_reg;

    // Build the next result word and XOR
    always_comb
    begin
        xor_next   = xor_reg;
        valid_next = valid_reg && res_stall;
        res_next   = res_reg;
        if (pop)
        begin
            if (emits)
            begin
                valid_next = 1'b1;
                res_next   = '0;
            end
            unique case (head.kind)
                TOK_CMD_HDR:
                begin
                    xor_next = head.first ? head.data : (xor_reg ^ head.data);
                end
                TOK_DATA_HDR:
                begin
                    xor_next = xor_reg;
                end
                TOK_PAY:
                begin
                    xor_next               = head.first ? head.data : (xor_reg ^ head.data);
                    res_next.event_res     = EV_PAYLOAD;
                    res_next.payload_byte  = head.data;
                    res_next.payload_index = head.index;
                end
                TOK_CMD_SUM:
                begin
                    res_next.event_res = EV_CMD;
                    res_next.field_a   = hdr_reg[0];
                    res_next.field_b   = hdr_reg[1];
                    res_next.field_c   = hdr_reg[2];
                    res_next.field_d   = hdr_reg[3];
                    res_next.check_ok  = (xor_reg == head.data);
                end
                TOK_DATA_SUM:
                begin
                    res_next.event_res = EV_DATA;
                    res_next.field_a   = hdr_reg[0];
                    res_next.field_b   = hdr_reg[1];
                    res_next.field_c   = hdr_reg[2];
                    res_next.check_ok  = (xor_reg == head.data);
                end
                TOK_ACK:
                begin
                    res_next.event_res = EV_ACK;
                    res_next.field_a   = head.data;
                    res_next.check_ok  = (head.data == 8'd0);
                end
                default:
                begin
                    xor_next = xor_reg;
                end
            endcase
        end
    end

    // Capture header bytes
    always_ff @(posedge clk)
    begin
        if (pop && (head.kind == TOK_CMD_HDR || head.kind == TOK_DATA_HDR))
        begin
            hdr_reg[slot] <= head.data;
        end
    end

    // Hold XOR and result payload
    always_ff @(posedge clk)
    begin
        xor_reg <= xor_next;
        res_reg <= res_next;
    end

    // Hold result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    `include "serial_packet_deframer_xor_check_unit_defines.svh"

    `SPDX_ASSERT_NEXT(a_emit_valid, clk, rst_n, pop && emits, valid_reg)

endmodule
`default_nettype wire

[rtl/serial_packet_deframer_xor_check_unit.sv]
// Top level of the serial packet deframer with XOR check.
//
// Input channel (item_valid, item_stall, item) carries one received serial
// word per unstalled cycle (rx_byte, overrun flag); flagged words are dropped.
// Output channel (res_valid, res_stall, res) carries one result word per
// payload byte and one per completed command, data or ack packet.
// An accepted word is classified by the front end, written into the queue,
// and its result is taken into the output register in the back end.
// Throughput: one word per cycle while not stalled, set by the combinational
// front classifier and the one-pop-per-cycle back end behind a two-entry queue.
// Start words are not queued; header words produce no result and leave the back end at once.
// Reset returns the block to hunting for a start word with the queue empty
// and no result pending.
// When the receiver stalls, the output register holds its word, the queue
// fills behind it, and item_stall rises once both queue entries are taken.
`default_nettype none
module serial_packet_deframer_xor_check_unit #(
    parameter int PAYLOAD_BYTES = 512
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    input  wire spdx_pkg::in_t  item,
    output logic                res_valid,
    input  wire logic           res_stall,
    output spdx_pkg::out_t      res
);
    import spdx_pkg::*;

    logic push;
    tok_t push_tok;
    logic pop;
    logic full;
    logic not_empty;
    tok_t head;

    assign item_stall = full;

    spdx_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_tok   (push_tok)
    );

    spdx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_tok  (push_tok),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    spdx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
`default_nettype wire
